// ===== src/prc_pkg.sv =====
// ----------------------------------------------------------------------------
// prc_pkg: shared types and constants of the polygon rectangle clipper
// Stage codes, register indexes, state types and list sizing.
// ----------------------------------------------------------------------------
`default_nettype none
package prc_pkg;

  localparam int LIST_DEPTH = 64;   // per-bank vertex list, holds the worst case of 46
  localparam int LIST_AW    = 6;
  localparam int QDEPTH     = 4;
  localparam int QAW        = 2;

  typedef enum logic [1:0] {
    CFG_MIN_X = 2'd0,
    CFG_MIN_Y = 2'd1,
    CFG_MAX_X = 2'd2,
    CFG_MAX_Y = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    STG_LEFT   = 2'd0,
    STG_RIGHT  = 2'd1,
    STG_BOTTOM = 2'd2,
    STG_TOP    = 2'd3
  } stage_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_RD,
    BK_LOAD,
    BK_EDGE,
    BK_DIV,
    BK_WE,
    BK_ADV,
    BK_NEXT,
    BK_EMIT_RD,
    BK_EMIT_LD,
    BK_FINAL
  } bk_state_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_MUL,
    DV_RUN,
    DV_DONE
  } dv_state_t;

  typedef struct packed {
    logic valid;
    logic last;
  } qhead_t;

endpackage
`default_nettype wire

// ===== src/prc_ifs.sv =====
// ----------------------------------------------------------------------------
// prc channel interfaces
// Vertex input channel and clipped-vertex result channel, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none
interface prc_in_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] vertex_x;
  logic signed [W-1:0] vertex_y;
  logic                last_vertex;

  modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
  modport sink   (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

interface prc_out_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] out_x;
  logic signed [W-1:0] out_y;
  logic                out_last;
  logic                out_empty;

  modport source (output valid, out_x, out_y, out_last, out_empty, input ready);
  modport sink   (input valid, out_x, out_y, out_last, out_empty, output ready);
endinterface
`default_nettype wire

// ===== src/polygon_rect_clipper_core.sv =====
// ----------------------------------------------------------------------------
// polygon_rect_clipper_core: polygon clipping against an axis-aligned window
// Clips left, right, bottom and top in turn; one input vertex per item.
// ----------------------------------------------------------------------------
// Usage:
//   in_vtx  : vertex items (vertex_x, vertex_y, last_vertex), valid/ready.
//   out_res : clipped vertices (out_x, out_y, out_last, out_empty).
//   cfg_*   : window registers, written while the block is idle.
// A vertex is queued by the intake (4 deep), then the clip engine runs the
// four boundary stages over a vertex list in block RAM, using the serial
// divider for each intersection; it takes the next queued vertex only
// once it has finished with the previous one.
// Clipped vertices appear one item late; the last one, flagged out_last,
// appears with the polygon end. A fully clipped polygon yields a single
// item with out_empty and out_last set.
// Reset clears the queue, all stage state and the held vertex, and loads
// the widest window. A stalled receiver holds the output register; the
// engine then waits, and the intake keeps taking vertices until full.
// ----------------------------------------------------------------------------
`default_nettype none
module polygon_rect_clipper_core import prc_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  prc_in_if.sink                      in_vtx,
  prc_out_if.source                   out_res,
  input  wire logic                   cfg_we,
  input  wire logic [1:0]             cfg_idx,
  input  wire logic [COORD_WIDTH-1:0] cfg_wdata
);

  qhead_t                        q_head;
  logic signed [COORD_WIDTH-1:0] q_x, q_y;
  logic                          q_pop;

  prc_front #(.W(COORD_WIDTH)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vtx (in_vtx),
    .q_head (q_head),
    .q_x    (q_x),
    .q_y    (q_y),
    .q_pop  (q_pop)
  );

  prc_back #(.W(COORD_WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .q_head    (q_head),
    .q_x       (q_x),
    .q_y       (q_y),
    .q_pop     (q_pop),
    .out_res   (out_res)
  );

endmodule
`default_nettype wire

// ===== src/prc_front.sv =====
// ----------------------------------------------------------------------------
// prc_front: vertex intake
// Accepts vertices, tags polygon ends and queues them for the clip engine.
// ----------------------------------------------------------------------------
`default_nettype none
module prc_front import prc_pkg::*; #(
  parameter int W = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  prc_in_if.sink             in_vtx,
  output qhead_t             q_head,
  output logic signed [W-1:0] q_x,
  output logic signed [W-1:0] q_y,
  input  wire logic          q_pop
);

  logic signed [W-1:0] fx_r [QDEPTH];
  logic signed [W-1:0] fy_r [QDEPTH];
  logic                fl_r [QDEPTH];
  logic [QAW-1:0]      wp_r, rp_r;
  logic [QAW:0]        cnt_r;
  logic                push, pop;

  assign in_vtx.ready = (cnt_r != QAW'(0) + (QAW+1)'(QDEPTH)) ? 1'b1 : 1'b0;
  assign push         = in_vtx.valid & in_vtx.ready;
  assign pop          = q_pop & q_head.valid;

  assign q_head.valid = (cnt_r != '0);
  assign q_head.last  = fl_r[rp_r];
  assign q_x          = fx_r[rp_r];
  assign q_y          = fy_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + QAW'(1);
      if (pop)  rp_r <= rp_r + QAW'(1);
      cnt_r <= cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fx_r[wp_r] <= in_vtx.vertex_x;
      fy_r[wp_r] <= in_vtx.vertex_y;
      fl_r[wp_r] <= in_vtx.last_vertex;
    end
  end

endmodule
`default_nettype wire

// ===== src/prc_div.sv =====
// ----------------------------------------------------------------------------
// prc_div: intersection offset unit
// base + trunc(num*t/den): one multiply, then a bit-serial restoring divide.
// ----------------------------------------------------------------------------
`default_nettype none
module prc_div import prc_pkg::*; #(
  parameter int W = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic signed [W:0]   num,
  input  wire logic signed [W:0]   tv,
  input  wire logic signed [W:0]   den,
  input  wire logic signed [W-1:0] base,
  output logic                     done,
  output logic signed [W-1:0]      res
);

  localparam int D  = W + 1;
  localparam int PW = 2 * D;
  localparam int CW = $clog2(PW + 1);

  dv_state_t           state_r, state_nxt;
  logic [D-1:0]        a_r, b_r, den_r, q_r;
  logic [PW-1:0]       prod_r;
  logic [D:0]          rem_r, r2;
  logic [CW-1:0]       cnt_r;
  logic                neg_r, zero_r, ge;
  logic signed [W-1:0] base_r;
  logic signed [D:0]   off;
  logic signed [D+1:0] sum;

  assign r2 = {rem_r[D-1:0], prod_r[PW-1]};
  assign ge = (r2 >= {1'b0, den_r});

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      DV_IDLE: if (start) state_nxt = DV_MUL;
      DV_MUL:  state_nxt = DV_RUN;
      DV_RUN:  if (cnt_r == CW'(1)) state_nxt = DV_DONE;
      DV_DONE: state_nxt = DV_IDLE;
      default: state_nxt = DV_IDLE;
    endcase
  end

  always_comb begin
    done = (state_r == DV_DONE);
    off  = zero_r ? '0 : (neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r}));
    sum  = {{3{base_r[W-1]}}, base_r} + {off[D], off};
    res  = sum[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= DV_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      DV_IDLE: begin
        if (start) begin
          a_r    <= num[D-1] ? D'(-num) : D'(num);
          b_r    <= tv[D-1]  ? D'(-tv)  : D'(tv);
          den_r  <= den[D-1] ? D'(-den) : D'(den);
          neg_r  <= num[D-1] ^ tv[D-1] ^ den[D-1];
          zero_r <= (den == '0);
          base_r <= base;
        end
      end
      DV_MUL: begin
        prod_r <= a_r * b_r;
        rem_r  <= '0;
        q_r    <= '0;
        cnt_r  <= CW'(PW);
      end
      DV_RUN: begin
        rem_r  <= ge ? r2 - {1'b0, den_r} : r2;
        q_r    <= {q_r[D-2:0], ge};
        prod_r <= {prod_r[PW-2:0], 1'b0};
        cnt_r  <= cnt_r - CW'(1);
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/prc_back.sv =====
// ----------------------------------------------------------------------------
// prc_back: clip engine
// Runs the four boundary stages over a ping-pong vertex list, then emits.
// ----------------------------------------------------------------------------
`default_nettype none
module prc_back import prc_pkg::*; #(
  parameter int W = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_idx,
  input  wire logic [W-1:0]        cfg_wdata,
  input  wire qhead_t              q_head,
  input  wire logic signed [W-1:0] q_x,
  input  wire logic signed [W-1:0] q_y,
  output logic                     q_pop,
  prc_out_if.source                out_res
);

  localparam int MAW = LIST_AW + 1;

  logic signed [W-1:0] min_x_r, min_y_r, max_x_r, max_y_r;
  bk_state_t           state_r, state_nxt;
  stage_t              stage_r;
  logic                bank_r, end_r, closing_r;
  logic [LIST_AW:0]    idx_r, n_r, cnt_r;
  logic signed [W-1:0] cx_r, cy_r;
  logic signed [W-1:0] px_r [4];
  logic signed [W-1:0] py_r [4];
  logic signed [W-1:0] fx_r [4];
  logic signed [W-1:0] fy_r [4];
  logic [3:0]          have_first_r;
  logic                pv_r;
  logic signed [W-1:0] pend_x_r, pend_y_r;
  logic [2*W-1:0]      mem [2*LIST_DEPTH];
  logic [2*W-1:0]      rd_data_r;
  logic                ov_r, olast_r, oempty_r;
  logic signed [W-1:0] ox_r, oy_r;

  logic                wr_en, rd_en;
  logic [MAW-1:0]      wr_addr, rd_addr;
  logic [2*W-1:0]      wr_data;
  logic signed [W-1:0] px, py, bnd, ix, iy, dv_res, rx, ry;
  logic signed [W:0]   dv_num, dv_t, dv_den;
  logic signed [W-1:0] dv_base;
  logic                vert, in_c, in_p, crossing, more, slot_free, dv_start, dv_done;
  logic                ov_set;

  assign px        = px_r[stage_r];
  assign py        = py_r[stage_r];
  assign vert      = (stage_r == STG_LEFT) || (stage_r == STG_RIGHT);
  assign more      = (idx_r < n_r);
  assign slot_free = !ov_r || out_res.ready;
  assign crossing  = in_c ^ in_p;
  assign rx        = rd_data_r[2*W-1:W];
  assign ry        = rd_data_r[W-1:0];
  // output register loads a new item
  assign ov_set    = slot_free &&
                     (((state_r == BK_EMIT_LD) && pv_r) || (state_r == BK_FINAL));

  always_comb begin
    unique case (stage_r)
      STG_LEFT: begin
        bnd = min_x_r; in_c = (cx_r >= min_x_r); in_p = (px >= min_x_r);
      end
      STG_RIGHT: begin
        bnd = max_x_r; in_c = (cx_r <= max_x_r); in_p = (px <= max_x_r);
      end
      STG_BOTTOM: begin
        bnd = min_y_r; in_c = (cy_r >= min_y_r); in_p = (py >= min_y_r);
      end
      default: begin
        bnd = max_y_r; in_c = (cy_r <= max_y_r); in_p = (py <= max_y_r);
      end
    endcase
  end

  // vertical boundary solves for y, horizontal for x
  always_comb begin
    if (vert) begin
      dv_num  = {cy_r[W-1], cy_r} - {py[W-1], py};
      dv_t    = {bnd[W-1], bnd} - {px[W-1], px};
      dv_den  = {cx_r[W-1], cx_r} - {px[W-1], px};
      dv_base = py;
      ix      = bnd;
      iy      = dv_res;
    end else begin
      dv_num  = {cx_r[W-1], cx_r} - {px[W-1], px};
      dv_t    = {bnd[W-1], bnd} - {py[W-1], py};
      dv_den  = {cy_r[W-1], cy_r} - {py[W-1], py};
      dv_base = px;
      ix      = dv_res;
      iy      = bnd;
    end
  end

  prc_div #(.W(W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .num   (dv_num),
    .tv    (dv_t),
    .den   (dv_den),
    .base  (dv_base),
    .done  (dv_done),
    .res   (dv_res)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE:    if (q_head.valid) state_nxt = BK_RD;
      BK_RD: begin
        if (more)                                   state_nxt = BK_LOAD;
        else if (end_r && have_first_r[stage_r])    state_nxt = BK_EDGE;
        else                                        state_nxt = BK_NEXT;
      end
      BK_LOAD:    state_nxt = have_first_r[stage_r] ? BK_EDGE : BK_RD;
      BK_EDGE: begin
        if (crossing)  state_nxt = BK_DIV;
        else if (in_c) state_nxt = BK_WE;
        else           state_nxt = BK_ADV;
      end
      BK_DIV:     if (dv_done) state_nxt = in_c ? BK_WE : BK_ADV;
      BK_WE:      state_nxt = BK_ADV;
      BK_ADV:     state_nxt = closing_r ? BK_NEXT : BK_RD;
      BK_NEXT:    state_nxt = (stage_r == STG_TOP) ? BK_EMIT_RD : BK_RD;
      BK_EMIT_RD: begin
        if (more)       state_nxt = BK_EMIT_LD;
        else if (end_r) state_nxt = BK_FINAL;
        else            state_nxt = BK_IDLE;
      end
      BK_EMIT_LD: if (!pv_r || slot_free) state_nxt = BK_EMIT_RD;
      BK_FINAL:   if (slot_free) state_nxt = BK_IDLE;
      default:    state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = (state_r == BK_IDLE) && q_head.valid;
    dv_start = (state_r == BK_EDGE) && crossing;
    rd_en    = ((state_r == BK_RD) || (state_r == BK_EMIT_RD)) && more;
    rd_addr  = {bank_r, idx_r[LIST_AW-1:0]};
    wr_en    = 1'b0;
    wr_addr  = {!bank_r, cnt_r[LIST_AW-1:0]};
    wr_data  = {cx_r, cy_r};
    unique case (state_r)
      BK_IDLE: begin
        wr_en   = q_head.valid;
        wr_addr = '0;
        wr_data = {q_x, q_y};
      end
      BK_DIV: begin
        wr_en   = dv_done;
        wr_data = {ix, iy};
      end
      BK_WE:   wr_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_x_r <= {1'b1, {(W-1){1'b0}}};
      min_y_r <= {1'b1, {(W-1){1'b0}}};
      max_x_r <= {1'b0, {(W-1){1'b1}}};
      max_y_r <= {1'b0, {(W-1){1'b1}}};
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_MIN_X: min_x_r <= cfg_wdata;
        CFG_MIN_Y: min_y_r <= cfg_wdata;
        CFG_MAX_X: max_x_r <= cfg_wdata;
        CFG_MAX_Y: max_y_r <= cfg_wdata;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_IDLE;
      have_first_r <= '0;
      pv_r         <= 1'b0;
      ov_r         <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ov_set)             ov_r <= 1'b1;
      else if (out_res.ready) ov_r <= 1'b0;
      unique case (state_r)
        BK_LOAD: if (!have_first_r[stage_r]) have_first_r[stage_r] <= 1'b1;
        BK_ADV:  if (closing_r) have_first_r[stage_r] <= 1'b0;
        BK_EMIT_LD: begin
          if (!pv_r) pv_r <= 1'b1;
        end
        BK_FINAL: begin
          if (slot_free) pv_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      BK_IDLE: begin
        end_r     <= q_head.last;
        n_r       <= (LIST_AW+1)'(1);
        cnt_r     <= '0;
        idx_r     <= '0;
        stage_r   <= STG_LEFT;
        bank_r    <= 1'b0;
        closing_r <= 1'b0;
      end
      BK_RD: begin
        if (!more && end_r && have_first_r[stage_r]) begin
          cx_r      <= fx_r[stage_r];
          cy_r      <= fy_r[stage_r];
          closing_r <= 1'b1;
        end
      end
      BK_LOAD: begin
        cx_r <= rx;
        cy_r <= ry;
        if (!have_first_r[stage_r]) begin
          fx_r[stage_r] <= rx;
          fy_r[stage_r] <= ry;
          px_r[stage_r] <= rx;
          py_r[stage_r] <= ry;
          idx_r         <= idx_r + (LIST_AW+1)'(1);
        end
      end
      BK_DIV:  if (dv_done) cnt_r <= cnt_r + (LIST_AW+1)'(1);
      BK_WE:   cnt_r <= cnt_r + (LIST_AW+1)'(1);
      BK_ADV: begin
        px_r[stage_r] <= cx_r;
        py_r[stage_r] <= cy_r;
        if (closing_r) closing_r <= 1'b0;
        else           idx_r     <= idx_r + (LIST_AW+1)'(1);
      end
      BK_NEXT: begin
        bank_r  <= !bank_r;
        n_r     <= cnt_r;
        cnt_r   <= '0;
        idx_r   <= '0;
        stage_r <= stage_t'(stage_r + 2'd1);
      end
      BK_EMIT_LD: begin
        if (!pv_r || slot_free) begin
          pend_x_r <= rx;
          pend_y_r <= ry;
          idx_r    <= idx_r + (LIST_AW+1)'(1);
        end
        if (pv_r && slot_free) begin
          ox_r     <= pend_x_r;
          oy_r     <= pend_y_r;
          olast_r  <= 1'b0;
          oempty_r <= 1'b0;
        end
      end
      BK_FINAL: begin
        if (slot_free) begin
          ox_r     <= pv_r ? pend_x_r : '0;
          oy_r     <= pv_r ? pend_y_r : '0;
          olast_r  <= 1'b1;
          oempty_r <= !pv_r;
        end
      end
      default: ;
    endcase
  end

  assign out_res.valid     = ov_r;
  assign out_res.out_x     = ox_r;
  assign out_res.out_y     = oy_r;
  assign out_res.out_last  = olast_r;
  assign out_res.out_empty = oempty_r;

`ifndef SYNTHESIS
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.out_empty |-> out_res.out_last)
    else $error("empty item without last flag");

  a_list_fits: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && (state_r != BK_IDLE) |-> cnt_r < (LIST_AW+1)'(LIST_DEPTH))
    else $error("vertex list overflow");

  a_final_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_FINAL) && slot_free |=> out_res.valid && out_res.out_last)
    else $error("polygon end not emitted");
`endif

endmodule
`default_nettype wire

// ===== tb/prc_tb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_tb_checker: clipped-vertex predictor and scoreboard
// Mirrors the window registers and the four clip stages, queues the expected
// clipped vertices per accepted input item and compares every output item.
// ----------------------------------------------------------------------------
module prc_tb_checker import prc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  prc_in_if                in_vtx,
  prc_out_if               out_res,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_idx,
  input  wire logic [15:0] cfg_wdata,
  output int               fail_count,
  output int               pending
);

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               last;
    logic               empty;
  } clip_vtx_t;

  typedef struct {
    longint x[$];
    longint y[$];
  } vlist_t;

  longint win_lo_x, win_lo_y, win_hi_x, win_hi_y;
  longint first_x[4], first_y[4], prev_x[4], prev_y[4];
  bit     have_first[4];
  bit     hold_valid;
  longint hold_x, hold_y;
  clip_vtx_t clipped_q[$];

  assign pending = clipped_q.size();

  function automatic bit in_window(int e, longint x, longint y);
    case (e)
      STG_LEFT:   return x >= win_lo_x;
      STG_RIGHT:  return x <= win_hi_x;
      STG_BOTTOM: return y >= win_lo_y;
      default:    return y <= win_hi_y;
    endcase
  endfunction

  // num*t/den truncated toward zero; products fit in 64 bits here
  function automatic longint trunc_div(longint num, longint t, longint den);
    longint p;
    if (den == 0) return 0;
    p = num * t;
    return p / den;
  endfunction

  function automatic void add_point(ref vlist_t o, input longint x, input longint y);
    o.x = {o.x, x};
    o.y = {o.y, y};
  endfunction

  function automatic void clip_edge(int e, longint sx, longint sy, longint ex, longint ey,
                                    ref vlist_t o);
    bit ie, is;
    longint b;
    ie = in_window(e, ex, ey);
    is = in_window(e, sx, sy);
    if (ie != is) begin
      if (e < 2) begin
        b = (e == STG_LEFT) ? win_lo_x : win_hi_x;
        add_point(o, b, sy + trunc_div(ey - sy, b - sx, ex - sx));
      end else begin
        b = (e == STG_BOTTOM) ? win_lo_y : win_hi_y;
        add_point(o, sx + trunc_div(ex - sx, b - sy, ey - sy), b);
      end
    end
    if (ie) add_point(o, ex, ey);
  endfunction

  function automatic void predict_vertex(longint vx, longint vy, bit fin);
    vlist_t a, b;
    clip_vtx_t c;
    add_point(a, vx, vy);
    for (int e = 0; e < 4; e++) begin
      b.x.delete();
      b.y.delete();
      foreach (a.x[i]) begin
        if (!have_first[e]) begin
          have_first[e] = 1;
          first_x[e] = a.x[i];
          first_y[e] = a.y[i];
        end else begin
          clip_edge(e, prev_x[e], prev_y[e], a.x[i], a.y[i], b);
        end
        prev_x[e] = a.x[i];
        prev_y[e] = a.y[i];
      end
      if (fin && have_first[e]) begin
        clip_edge(e, prev_x[e], prev_y[e], first_x[e], first_y[e], b);
        have_first[e] = 0;
      end
      a = b;
    end
    foreach (a.x[i]) begin
      if (hold_valid) begin
        c = '{hold_x[15:0], hold_y[15:0], 1'b0, 1'b0};
        clipped_q = {clipped_q, c};
      end
      hold_valid = 1;
      hold_x = a.x[i];
      hold_y = a.y[i];
    end
    if (fin) begin
      if (hold_valid) c = '{hold_x[15:0], hold_y[15:0], 1'b1, 1'b0};
      else c = '{16'sd0, 16'sd0, 1'b1, 1'b1};
      clipped_q = {clipped_q, c};
      hold_valid = 0;
    end
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    clip_vtx_t exp_v;
    if (!rst_n) begin
      win_lo_x = -32768; win_lo_y = -32768;
      win_hi_x = 32767;  win_hi_y = 32767;
      for (int e = 0; e < 4; e++) have_first[e] = 0;
      hold_valid = 0;
      clipped_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_MIN_X: win_lo_x = $signed(cfg_wdata);
          CFG_MIN_Y: win_lo_y = $signed(cfg_wdata);
          CFG_MAX_X: win_hi_x = $signed(cfg_wdata);
          default:   win_hi_y = $signed(cfg_wdata);
        endcase
      end
      if (in_vtx.valid && in_vtx.ready)
        predict_vertex(in_vtx.vertex_x, in_vtx.vertex_y, in_vtx.last_vertex);
      if (out_res.valid && out_res.ready) begin
        if (clipped_q.size() == 0) begin
          report_mismatch($sformatf("unexpected item x=%0d y=%0d",
                                    out_res.out_x, out_res.out_y));
        end else begin
          exp_v = clipped_q.pop_front();
          if (out_res.out_x !== exp_v.x || out_res.out_y !== exp_v.y ||
              out_res.out_last !== exp_v.last || out_res.out_empty !== exp_v.empty)
            report_mismatch($sformatf("got %0d,%0d l%b e%b want %0d,%0d l%b e%b",
              out_res.out_x, out_res.out_y, out_res.out_last, out_res.out_empty,
              exp_v.x, exp_v.y, exp_v.last, exp_v.empty));
        end
      end
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: polygon rectangle clipper testbench
// Streams directed and random polygons through several windows with random
// gaps on both channels; the checker predicts and compares each result.
// ----------------------------------------------------------------------------
module tb import prc_pkg::*;;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [1:0]  cfg_idx = CFG_MIN_X;
  logic [15:0] cfg_wdata = '0;
  int          fail_count, pending;
  int          cycles = 0;
  int          sent = 0;

  prc_in_if  #(16) in_vtx();
  prc_out_if #(16) out_res();

  always #5 clk = ~clk;

  polygon_rect_clipper_core #(.COORD_WIDTH(16)) uut (
    .clk, .rst_n, .in_vtx(in_vtx.sink), .out_res(out_res.source),
    .cfg_we, .cfg_idx, .cfg_wdata
  );

  prc_tb_checker chk (
    .clk, .rst_n, .in_vtx, .out_res, .cfg_we, .cfg_idx, .cfg_wdata,
    .fail_count, .pending
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // receiver stalls, including long ones
  initial begin
    out_res.ready = 0;
    forever begin
      @(negedge clk);
      if (cycles % 3000 < 600) out_res.ready = 1;
      else out_res.ready = (gap_len() == 0);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 20000000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_vertex(logic signed [15:0] x, logic signed [15:0] y, bit fin);
    int g;
    g = (cycles % 4000 < 800) ? 0 : gap_len();
    repeat (g) @(negedge clk);
    in_vtx.vertex_x = x;
    in_vtx.vertex_y = y;
    in_vtx.last_vertex = fin;
    in_vtx.valid = 1;
    do @(posedge clk); while (!in_vtx.ready);
    @(negedge clk);
    in_vtx.valid = 0;
    sent++;
  endtask

  task automatic set_window(int lx, int ly, int hx, int hy);
    int v[4];
    v = '{lx, ly, hx, hy};
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_we = 1;
      cfg_idx = cfg_idx_t'(i);
      cfg_wdata = v[i][15:0];
      @(negedge clk);
    end
    cfg_we = 0;
  endtask

  function automatic logic signed [15:0] rnd_coord(int lo, int hi);
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($urandom_range(0, hi - lo) + lo);
  endfunction

  task automatic rand_polygon(int lo, int hi);
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
    for (int i = 0; i < n; i++)
      send_vertex(rnd_coord(lo, hi), rnd_coord(lo, hi), i == n - 1);
  endtask

  initial begin
    in_vtx.valid = 0;
    in_vtx.vertex_x = '0;
    in_vtx.vertex_y = '0;
    in_vtx.last_vertex = 0;
    repeat (9) @(negedge clk);
    rst_n = 1;
    // directed, reset window: extremes and a single vertex
    send_vertex(-16'sd32768, -16'sd32768, 0);
    send_vertex(16'sd32767, -16'sd32768, 0);
    send_vertex(16'sd32767, 16'sd32767, 1);
    send_vertex(16'sd5, -16'sd7, 1);
    set_window(-160, -160, 160, 160);
    // crosses every boundary, square around the window
    send_vertex(-16'sd320, -16'sd320, 0);
    send_vertex(16'sd320, -16'sd320, 0);
    send_vertex(16'sd320, 16'sd320, 0);
    send_vertex(-16'sd320, 16'sd320, 1);
    // diamond cutting each edge
    send_vertex(16'sd0, -16'sd300, 0);
    send_vertex(16'sd300, 16'sd0, 0);
    send_vertex(16'sd0, 16'sd300, 0);
    send_vertex(-16'sd300, 16'sd0, 1);
    // fully clipped, on-boundary, single vertex outside
    send_vertex(16'sd1000, 16'sd1000, 0);
    send_vertex(16'sd2000, 16'sd1000, 0);
    send_vertex(16'sd1500, 16'sd2000, 1);
    send_vertex(16'sd160, -16'sd160, 0);
    send_vertex(-16'sd160, 16'sd160, 1);
    send_vertex(16'sd999, 16'sd0, 1);
    set_window(100, 100, -100, -100);  // inverted
    send_vertex(16'sd0, 16'sd0, 0);
    send_vertex(16'sd50, 16'sd0, 0);
    send_vertex(16'sd0, 16'sd50, 1);
    set_window(-32768, -32768, -32768, -32768);
    send_vertex(-16'sd32768, -16'sd32768, 0);
    send_vertex(16'sd32767, 16'sd32767, 1);
    // random phases over several windows
    for (int ph = 0; ph < 6; ph++) begin
      int lx, ly, sx, sy;
      lx = $urandom_range(0, 20000) - 10000;
      ly = $urandom_range(0, 20000) - 10000;
      sx = $urandom_range(1, 12000);
      sy = $urandom_range(1, 12000);
      if (ph == 5) set_window(32767, 32767, 32767, 32767);
      else if (ph == 0) set_window(-32768, -32768, 32767, 32767);
      else set_window(lx, ly, lx + sx, ly + sy);
      while (sent < 30 + 65 * (ph + 1))
        rand_polygon(lx - sx, lx + 2 * sx);
    end
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
